FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the RLE decoder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is high
`define BRE_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bre assertion failed");

// clocked property that also holds across reset
`define BRE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bre assertion failed");

`endif

FILE: src/bre_pkg.sv
// Shared types and constants of the BMP RLE8/RLE4 decoder.
// No dependencies; used by every other file but assert_macros.svh through scoped names.
package bre_pkg;

   // default size limits and the reset value of the size registers
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int CFG_SIZE_RST   = 4096;

   // config port
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_UP    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NIBBLE_MODE  = 8'd3;

   // result kinds
   localparam logic [2:0] KIND_RUN = 3'd0;
   localparam logic [2:0] KIND_LIT = 3'd1;
   localparam logic [2:0] KIND_EOL = 3'd2;
   localparam logic [2:0] KIND_EOP = 3'd3;
   localparam logic [2:0] KIND_OOB = 3'd4;

   // command codes from the parser to the executor
   localparam logic [2:0] OP_RUN = 3'd0;
   localparam logic [2:0] OP_EOL = 3'd1;
   localparam logic [2:0] OP_EOP = 3'd2;
   localparam logic [2:0] OP_DX  = 3'd3;
   localparam logic [2:0] OP_DY  = 3'd4;
   localparam logic [2:0] OP_LIT = 3'd5;

   localparam int CMD_DEPTH = 2;

   // count: run length, pixel count of a literal word, or delta amount
   typedef struct packed {
      logic [2:0] op;
      logic [7:0] count;
      logic [7:0] val_even;
      logic [7:0] val_odd;
   } cmd_type;

   typedef struct packed {
      logic init;
      logic nibble_mode;
      logic bottom_up;
   } ctl_type;

endpackage

FILE: src/bre_ifs.sv
// Valid/ready channel interfaces of the RLE decoder: stream in, spans out, config.
// Depends on bre_pkg for the config port widths.
interface bre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   modport source (output valid, output code_byte, input ready);
   modport sink   (input valid, input code_byte, output ready);
endinterface

interface bre_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [11:0] x_start;
   logic [11:0] line_index;
   logic [7:0]  span_length;
   logic [7:0]  value_even;
   logic [7:0]  value_odd;
   modport source (output valid, output kind, output x_start, output line_index,
                   output span_length, output value_even, output value_odd,
                   input ready);
   modport sink   (input valid, input kind, input x_start, input line_index,
                   input span_length, input value_even, input value_odd,
                   output ready);
endinterface

interface bre_csr_if;
   logic                         valid;
   logic                         ready;
   logic [bre_pkg::CSR_IDX_W-1:0] index;
   logic [bre_pkg::CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/bre_cmd_fifo.sv
// Short command queue between the byte parser and the span executor.
// Depends on bre_pkg (cmd_type, CMD_DEPTH).
module bre_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             flush,
   input  logic             push,
   input  bre_pkg::cmd_type wr_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output bre_pkg::cmd_type rd_data
);
   localparam int PW = (bre_pkg::CMD_DEPTH > 1) ? $clog2(bre_pkg::CMD_DEPTH) : 1;
   localparam int CW = $clog2(bre_pkg::CMD_DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(bre_pkg::CMD_DEPTH - 1);

   bre_pkg::cmd_type slot_ff [bre_pkg::CMD_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CW'(bre_pkg::CMD_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign rd_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: src/bre_front.sv
// Byte parser: tracks the RLE phase and turns stream words into commands.
// Depends on bre_pkg (cmd_type, ctl_type, OP_* codes).
module bre_front (
   input  logic             clock,
   input  logic             reset,
   input  bre_pkg::ctl_type ctl,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_byte,
   input  logic             fifo_full,
   output logic             push,
   output bre_pkg::cmd_type cmd
);
   localparam logic [2:0] PH_COUNT = 3'd0;
   localparam logic [2:0] PH_VALUE = 3'd1;
   localparam logic [2:0] PH_DX    = 3'd2;
   localparam logic [2:0] PH_DY    = 3'd3;
   localparam logic [2:0] PH_LIT   = 3'd4;
   localparam logic [2:0] PH_PAD   = 3'd5;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] held_count_ff, held_count_in;
   logic [7:0] literal_left_ff, literal_left_in;
   logic       pad_left_ff, pad_left_in;
   logic       fire;
   logic [8:0] byte_inc;
   logic [1:0] lit_n;

   assign in_ready = !fifo_full;
   assign fire     = in_valid && in_ready;
   assign byte_inc = {1'b0, in_byte} + 9'd1;
   assign lit_n    = !ctl.nibble_mode ? 2'd1 :
                     (literal_left_ff < 8'd2) ? literal_left_ff[1:0] : 2'd2;

   always_comb begin
      phase_in        = phase_ff;
      held_count_in   = held_count_ff;
      literal_left_in = literal_left_ff;
      pad_left_in     = pad_left_ff;
      push            = 1'b0;
      cmd.op          = bre_pkg::OP_RUN;
      cmd.count       = in_byte;
      cmd.val_even    = in_byte;
      cmd.val_odd     = in_byte;
      if (fire) begin
         unique case (phase_ff)
            PH_COUNT: begin
               held_count_in = in_byte;
               phase_in      = PH_VALUE;
            end
            PH_VALUE: begin
               phase_in = PH_COUNT;
               if (held_count_ff != 8'd0) begin
                  push      = 1'b1;
                  cmd.op    = bre_pkg::OP_RUN;
                  cmd.count = held_count_ff;
                  if (ctl.nibble_mode) begin
                     cmd.val_even = {4'd0, in_byte[7:4]};
                     cmd.val_odd  = {4'd0, in_byte[3:0]};
                  end
               end else if (in_byte == 8'd0) begin
                  push   = 1'b1;
                  cmd.op = bre_pkg::OP_EOL;
               end else if (in_byte == 8'd1) begin
                  push   = 1'b1;
                  cmd.op = bre_pkg::OP_EOP;
               end else if (in_byte == 8'd2) begin
                  phase_in = PH_DX;
               end else begin
                  // absolute mode; pad to a 16-bit boundary after odd byte count
                  literal_left_in = in_byte;
                  pad_left_in     = ctl.nibble_mode ? byte_inc[1] : in_byte[0];
                  phase_in        = PH_LIT;
               end
            end
            PH_DX: begin
               push     = 1'b1;
               cmd.op   = bre_pkg::OP_DX;
               phase_in = PH_DY;
            end
            PH_DY: begin
               push     = 1'b1;
               cmd.op   = bre_pkg::OP_DY;
               phase_in = PH_COUNT;
            end
            PH_LIT: begin
               push      = 1'b1;
               cmd.op    = bre_pkg::OP_LIT;
               cmd.count = {6'd0, lit_n};
               if (ctl.nibble_mode) begin
                  cmd.val_even = {4'd0, in_byte[7:4]};
                  cmd.val_odd  = (lit_n == 2'd2) ? {4'd0, in_byte[3:0]} : 8'd0;
               end else begin
                  cmd.val_odd = 8'd0;
               end
               literal_left_in = literal_left_ff - {6'd0, lit_n};
               if (literal_left_ff == {6'd0, lit_n}) begin
                  phase_in = pad_left_ff ? PH_PAD : PH_COUNT;
               end
            end
            PH_PAD: begin
               pad_left_in = 1'b0;
               phase_in    = PH_COUNT;
            end
            default: begin
               phase_in = PH_COUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         phase_ff        <= PH_COUNT;
         held_count_ff   <= 8'd0;
         literal_left_ff <= 8'd0;
         pad_left_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         held_count_ff   <= held_count_in;
         literal_left_ff <= literal_left_in;
         pad_left_ff     <= pad_left_in;
      end
   end

endmodule

FILE: src/bre_back.sv
// Span executor: keeps column, line and end-of-picture flag, and fills the
// result register from queued commands. Depends on bre_pkg.
module bre_back #(
   parameter int MAX_WIDTH  = bre_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bre_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bre_pkg::ctl_type                        ctl,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]          eff_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]         eff_h,
   input  logic signed [$clog2(MAX_HEIGHT+1):0]    init_line,
   input  logic                                    cmd_valid,
   input  bre_pkg::cmd_type                        cmd,
   output logic                                    cmd_pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [2:0]                              rsp_kind,
   output logic [11:0]                             rsp_x_start,
   output logic [11:0]                             rsp_line_index,
   output logic [7:0]                              rsp_span_length,
   output logic [7:0]                              rsp_value_even,
   output logic [7:0]                              rsp_value_odd
);
   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int LW = HW + 1;
   localparam int SW = XW + 9;
   localparam int DW = LW + 9;
   localparam logic signed [DW-1:0] LINE_MIN = -1;
   localparam logic signed [DW-1:0] LINE_MAX = DW'(MAX_HEIGHT);

   function automatic logic in_pic(input logic signed [LW-1:0] l,
                                   input logic [HW-1:0] h);
      return !l[LW-1] && (l[LW-2:0] < h);
   endfunction

   function automatic logic signed [LW-1:0] clamp_line(input logic signed [DW-1:0] v);
      if (v < LINE_MIN) return '1;
      if (v > LINE_MAX) return LW'(MAX_HEIGHT);
      return v[LW-1:0];
   endfunction

   function automatic logic [11:0] line_field(input logic signed [LW-1:0] l);
      return l[LW-1] ? 12'd0 : 12'(l[LW-2:0]);
   endfunction

   logic [XW-1:0]        x_pos_ff, x_pos_in;
   logic signed [LW-1:0] cur_line_ff, cur_line_in;
   logic                 done_ff, done_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           kind_ff, kind_in;
   logic [11:0]          x_start_ff, x_start_in;
   logic [11:0]          line_ff, line_in;
   logic [7:0]           len_ff, len_in;
   logic [7:0]           ve_ff, ve_in;
   logic [7:0]           vo_ff, vo_in;

   logic                 out_free, line_ok, eol_ok;
   logic [XW-1:0]        room;
   logic [7:0]           run_len;
   logic [SW-1:0]        x_plus_cnt, x_plus_len;
   logic signed [DW-1:0] line_d, step_d, line_step;
   logic signed [LW-1:0] stepped_line;
   logic [11:0]          oob_x;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cmd_pop  = cmd_valid && out_free;

   assign line_ok    = in_pic(cur_line_ff, eff_h);
   assign room       = (x_pos_ff >= eff_w) ? '0 : eff_w - x_pos_ff;
   assign run_len    = (SW'(cmd.count) < SW'(room)) ? cmd.count : 8'(room);
   assign x_plus_cnt = SW'(x_pos_ff) + SW'(cmd.count);
   assign x_plus_len = SW'(x_pos_ff) + SW'(run_len);
   assign oob_x      = (32'(x_pos_ff) > 32'd4095) ? 12'hFFF : 12'(x_pos_ff);

   // end of line steps by one, delta steps by the count byte
   assign line_d       = DW'(cur_line_ff);
   assign step_d       = (cmd.op == bre_pkg::OP_EOL) ? DW'(1) : $signed(DW'(cmd.count));
   assign line_step    = ctl.bottom_up ? line_d - step_d : line_d + step_d;
   assign stepped_line = clamp_line(line_step);
   assign eol_ok       = in_pic(stepped_line, eff_h);

   always_comb begin
      x_pos_in     = x_pos_ff;
      cur_line_in  = cur_line_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      x_start_in   = x_start_ff;
      line_in      = line_ff;
      len_in       = len_ff;
      ve_in        = ve_ff;
      vo_in        = vo_ff;
      if (cmd_pop && !done_ff) begin
         unique case (cmd.op)
            bre_pkg::OP_RUN: begin
               if (run_len != 8'd0) begin
                  rsp_valid_in = 1'b1;
                  if (!line_ok) begin
                     kind_in    = bre_pkg::KIND_OOB;
                     x_start_in = oob_x;
                     line_in    = line_field(cur_line_ff);
                     len_in     = 8'd0;
                     ve_in      = 8'd0;
                     vo_in      = 8'd0;
                     done_in    = 1'b1;
                  end else begin
                     kind_in    = bre_pkg::KIND_RUN;
                     x_start_in = 12'(x_pos_ff);
                     line_in    = line_field(cur_line_ff);
                     len_in     = run_len;
                     ve_in      = cmd.val_even;
                     vo_in      = cmd.val_odd;
                     x_pos_in   = XW'(x_plus_len);
                  end
               end
            end
            bre_pkg::OP_EOL: begin
               rsp_valid_in = 1'b1;
               x_pos_in     = '0;
               cur_line_in  = stepped_line;
               x_start_in   = 12'd0;
               len_in       = 8'd0;
               ve_in        = 8'd0;
               vo_in        = 8'd0;
               if (eol_ok) begin
                  kind_in = bre_pkg::KIND_EOL;
                  line_in = line_field(cur_line_ff);
               end else begin
                  kind_in = bre_pkg::KIND_EOP;
                  line_in = 12'd0;
                  done_in = 1'b1;
               end
            end
            bre_pkg::OP_EOP: begin
               rsp_valid_in = 1'b1;
               kind_in      = bre_pkg::KIND_EOP;
               x_start_in   = 12'd0;
               line_in      = 12'd0;
               len_in       = 8'd0;
               ve_in        = 8'd0;
               vo_in        = 8'd0;
               done_in      = 1'b1;
            end
            bre_pkg::OP_DX: begin
               x_pos_in = (x_plus_cnt > SW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(x_plus_cnt);
            end
            bre_pkg::OP_DY: begin
               cur_line_in = stepped_line;
            end
            bre_pkg::OP_LIT: begin
               rsp_valid_in = 1'b1;
               line_in      = line_field(cur_line_ff);
               if (!line_ok || x_plus_cnt > SW'(eff_w)) begin
                  kind_in    = bre_pkg::KIND_OOB;
                  x_start_in = oob_x;
                  len_in     = 8'd0;
                  ve_in      = 8'd0;
                  vo_in      = 8'd0;
                  done_in    = 1'b1;
               end else begin
                  kind_in    = bre_pkg::KIND_LIT;
                  x_start_in = 12'(x_pos_ff);
                  len_in     = cmd.count;
                  ve_in      = cmd.val_even;
                  vo_in      = cmd.val_odd;
                  x_pos_in   = XW'(x_plus_cnt);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         x_pos_ff    <= '0;
         cur_line_ff <= init_line;
         done_ff     <= 1'b0;
      end else begin
         x_pos_ff    <= x_pos_in;
         cur_line_ff <= cur_line_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      x_start_ff <= x_start_in;
      line_ff    <= line_in;
      len_ff     <= len_in;
      ve_ff      <= ve_in;
      vo_ff      <= vo_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_x_start     = x_start_ff;
   assign rsp_line_index  = line_ff;
   assign rsp_span_length = len_ff;
   assign rsp_value_even  = ve_ff;
   assign rsp_value_odd   = vo_ff;

endmodule

FILE: src/bmp_rle_decoder_core.sv
// Top level of the BMP RLE8/RLE4 stream decoder: config registers, parser,
// command queue, span executor. Depends on bre_pkg, bre_ifs, bre_front,
// bre_cmd_fifo and bre_back.
//
//   channel   dir   word                      accepted when
//   -------   ---   -----------------------   ---------------------------
//   req_bus   in    one compressed byte        req_bus.valid & req_bus.ready
//   rsp_bus   out   one span/event result      rsp_bus.valid & rsp_bus.ready
//   csr_bus   in    register index + data      csr_bus.valid (ready tied high)
//
// Throughput: one word per cycle on req_bus when rsp_bus is not stalled.
// An accepted byte's command is written into the queue, then loaded into the result register.
// The parser stalls only when the command queue is full; the executor stalls
//   only when the result register holds a word that rsp_bus has not taken.
// Reset, or a write to a known register, returns parser and executor to the
//   start of a picture; the new register value applies from that edge on.
module bmp_rle_decoder_core #(
   parameter int MAX_WIDTH  = bre_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bre_pkg::MAX_HEIGHT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bre_req_if.sink    req_bus,
   bre_rsp_if.source  rsp_bus,
   bre_csr_if.sink    csr_bus
);
   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int LW = HW + 1;
   localparam logic [XW-1:0] EFF_W_RST =
      XW'((bre_pkg::CFG_SIZE_RST < MAX_WIDTH) ? bre_pkg::CFG_SIZE_RST : MAX_WIDTH);
   localparam logic [HW-1:0] EFF_H_RST =
      HW'((bre_pkg::CFG_SIZE_RST < MAX_HEIGHT) ? bre_pkg::CFG_SIZE_RST : MAX_HEIGHT);

   // sizes are kept already clipped to the build limits
   logic [XW-1:0]        eff_w_ff, eff_w_in;
   logic [HW-1:0]        eff_h_ff, eff_h_in;
   logic                 bottom_up_ff, bottom_up_in;
   logic                 nibble_mode_ff, nibble_mode_in;
   logic                 csr_fire, cfg_hit;
   logic                 start_bu;
   logic [HW-1:0]        start_h;
   logic signed [LW-1:0] init_line;
   bre_pkg::ctl_type     ctl;

   logic                 fifo_full, fifo_push, fifo_pop, fifo_has;
   bre_pkg::cmd_type     push_cmd, head_cmd;

   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid;

   always_comb begin
      eff_w_in       = eff_w_ff;
      eff_h_in       = eff_h_ff;
      bottom_up_in   = bottom_up_ff;
      nibble_mode_in = nibble_mode_ff;
      cfg_hit        = 1'b0;
      if (csr_fire) begin
         unique case (csr_bus.index)
            bre_pkg::REG_IMAGE_WIDTH: begin
               cfg_hit  = 1'b1;
               eff_w_in = (32'(csr_bus.data) > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH)
                                                               : XW'(csr_bus.data);
            end
            bre_pkg::REG_IMAGE_HEIGHT: begin
               cfg_hit  = 1'b1;
               eff_h_in = (32'(csr_bus.data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                                : HW'(csr_bus.data);
            end
            bre_pkg::REG_BOTTOM_UP: begin
               cfg_hit      = 1'b1;
               bottom_up_in = csr_bus.data[0];
            end
            bre_pkg::REG_NIBBLE_MODE: begin
               cfg_hit        = 1'b1;
               nibble_mode_in = csr_bus.data[0];
            end
            default: begin
               // unknown index: dropped, parser state kept
            end
         endcase
      end
   end

   // first line of a picture, taken from the values that hold after this edge
   assign start_bu  = reset ? 1'b1 : bottom_up_in;
   assign start_h   = reset ? EFF_H_RST : eff_h_in;
   assign init_line = start_bu ? ($signed({1'b0, start_h}) - $signed(LW'(1))) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff       <= EFF_W_RST;
         eff_h_ff       <= EFF_H_RST;
         bottom_up_ff   <= 1'b1;
         nibble_mode_ff <= 1'b0;
      end else begin
         eff_w_ff       <= eff_w_in;
         eff_h_ff       <= eff_h_in;
         bottom_up_ff   <= bottom_up_in;
         nibble_mode_ff <= nibble_mode_in;
      end
   end

   assign ctl.init        = cfg_hit;
   assign ctl.nibble_mode = nibble_mode_ff;
   assign ctl.bottom_up   = bottom_up_ff;

   bre_front u_front (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_byte   (req_bus.code_byte),
      .fifo_full (fifo_full),
      .push      (fifo_push),
      .cmd       (push_cmd)
   );

   bre_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .flush     (cfg_hit),
      .push      (fifo_push),
      .wr_data   (push_cmd),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .not_empty (fifo_has),
      .rd_data   (head_cmd)
   );

   bre_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .eff_w           (eff_w_ff),
      .eff_h           (eff_h_ff),
      .init_line       (init_line),
      .cmd_valid       (fifo_has),
      .cmd             (head_cmd),
      .cmd_pop         (fifo_pop),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_kind        (rsp_bus.kind),
      .rsp_x_start     (rsp_bus.x_start),
      .rsp_line_index  (rsp_bus.line_index),
      .rsp_span_length (rsp_bus.span_length),
      .rsp_value_even  (rsp_bus.value_even),
      .rsp_value_odd   (rsp_bus.value_odd)
   );

endmodule

FILE: src/bre_checker.sv
// Port-level checks on the RLE decoder's result channel, bound to the top.
// Depends on bre_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bre_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  kind,
   input logic [11:0] x_start,
   input logic [11:0] line_index,
   input logic [7:0]  span_length
);
   logic is_span;

   assign is_span = (kind == bre_pkg::KIND_RUN) || (kind == bre_pkg::KIND_LIT);

   // a stalled result word holds
   `BRE_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(x_start) && $stable(line_index) && $stable(span_length))

   // spans always cover at least one pixel, events cover none
   `BRE_ASSERT_RST(a_span_nonzero, clock, reset, rsp_valid && is_span |-> span_length != 8'd0)
   `BRE_ASSERT_RST(a_event_empty, clock, reset, rsp_valid && !is_span |-> span_length == 8'd0)

   // end of picture carries no position
   `BRE_ASSERT_RST(a_eop_clear, clock, reset, rsp_valid && kind == bre_pkg::KIND_EOP |-> x_start == 12'd0 && line_index == 12'd0)

   // nothing is offered right after reset
   `BRE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind bmp_rle_decoder_core bre_checker u_bre_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .kind        (rsp_bus.kind),
   .x_start     (rsp_bus.x_start),
   .line_index  (rsp_bus.line_index),
   .span_length (rsp_bus.span_length)
);
